### rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX_HI  = 4'd3,
    PH_PAIR_BS = 4'd4,
    PH_PAIR_U  = 4'd5,
    PH_HEX_LO  = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_OPEN   = 3'd1,
    ERR_CTRL_CHAR = 3'd2,
    ERR_BAD_ESC   = 3'd3,
    ERR_BAD_HEX   = 3'd4,
    ERR_BAD_PAIR  = 3'd5,
    ERR_LONE_LOW  = 3'd6,
    ERR_EARLY_END = 3'd7
  } err_t;

  // one decoded request: a code point or raw byte to expand, or a status
  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [20:0] cp;
    logic [1:0]  len_m1;  // number of utf-8 bytes minus one
  } cmd_t;

endpackage : jsu_pkg
`default_nettype wire

### rtl/core/jsu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// valid/ready channels for raw input bytes and decoded results
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       input_ends;

  modport source (output valid, output in_byte, output input_ends, input ready);
  modport sink (input valid, input in_byte, input input_ends, output ready);
endinterface : jsu_in_if

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output out_kind, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input out_kind, input error_code,
                input last_of_run, output ready);
endinterface : jsu_out_if
`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// json string literal unescaper producing utf-8 bytes and status results
// ----------------------------------------------------------------------------
// path: a taken byte's request is written into the request queue; its results
//   then pass to the output register, one per cycle while the receiver is ready
// throughput: one input byte per cycle while the queue has room, one result
//   per cycle at the output port; a \u escape or surrogate pair yields up to
//   four results, absorbed by the request queue between front and back end
// reset: synchronous, clears parse state, queue pointers and output valid
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  // request from the parser to the expander
  jsu_pkg::cmd_t push_cmd;
  jsu_pkg::cmd_t pop_cmd;
  logic          push_valid, push_ready;
  logic          pop_valid, pop;

  // front end: quote/escape/hex tracking, one request per producing byte
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decoupling queue, lets the parser run ahead while multi-byte runs drain
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  // back end: utf-8 encoder feeding the output register
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule : json_string_unescape_utf8
`default_nettype wire

### rtl/core/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// parses raw bytes, tracks escape state, issues one request per result group
// ----------------------------------------------------------------------------
module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  jsu_in_if.sink             in_ch,
  output jsu_pkg::cmd_t      push_cmd,
  output logic               push_valid,
  input  wire logic          push_ready
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     code_unit, code_unit_next;
  logic [9:0]      high_part, high_part_next;
  logic [1:0]      hex_digits_seen, hex_digits_seen_next;

  logic        acc;
  logic [7:0]  b;
  logic [3:0]  hex_val;
  logic        hex_ok;
  logic [15:0] cu_shift;
  logic        is_hi, is_lo;
  logic        cmd_valid;
  logic [20:0] pair_cp;

  assign b      = in_ch.in_byte;
  assign acc    = in_ch.valid & in_ch.ready;
  assign in_ch.ready = push_ready;
  assign push_valid  = acc & cmd_valid;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      hex_val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      hex_val = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cu_shift = {code_unit[11:0], hex_val};
  assign is_hi    = (cu_shift[15:10] == 6'b110110);
  assign is_lo    = (cu_shift[15:10] == 6'b110111);
  // 0x10000 + (high << 10) + low offset
  assign pair_cp  = 21'h10000 + {1'b0, high_part, cu_shift[9:0]};

  // next state
  always_comb begin
    phase_next           = phase;
    code_unit_next       = code_unit;
    high_part_next       = high_part;
    hex_digits_seen_next = hex_digits_seen;
    if (in_ch.input_ends) begin
      phase_next           = jsu_pkg::PH_WAIT;
      code_unit_next       = '0;
      high_part_next       = '0;
      hex_digits_seen_next = '0;
    end else begin
      case (phase)
        jsu_pkg::PH_STR: begin
          if (b == CH_QUOTE || b <= 8'h1F) begin
            phase_next = jsu_pkg::PH_WAIT;
          end else if (b == CH_BSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
              b == CH_F || b == CH_N || b == CH_R || b == CH_T) begin
            phase_next = jsu_pkg::PH_STR;
          end else if (b == CH_U) begin
            phase_next           = jsu_pkg::PH_HEX_HI;
            code_unit_next       = '0;
            hex_digits_seen_next = '0;
          end else begin
            phase_next = jsu_pkg::PH_WAIT;
          end
        end
        jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
          if (!hex_ok) begin
            phase_next           = jsu_pkg::PH_WAIT;
            code_unit_next       = '0;
            high_part_next       = '0;
            hex_digits_seen_next = '0;
          end else if (hex_digits_seen != 2'd3) begin
            code_unit_next       = cu_shift;
            hex_digits_seen_next = hex_digits_seen + 2'd1;
          end else begin
            hex_digits_seen_next = '0;
            code_unit_next       = '0;
            if (phase == jsu_pkg::PH_HEX_HI) begin
              if (is_hi) begin
                phase_next     = jsu_pkg::PH_PAIR_BS;
                high_part_next = cu_shift[9:0];
                code_unit_next = cu_shift;
              end else if (is_lo) begin
                phase_next = jsu_pkg::PH_WAIT;
              end else begin
                phase_next = jsu_pkg::PH_STR;
              end
            end else begin
              high_part_next = '0;
              phase_next     = is_lo ? jsu_pkg::PH_STR : jsu_pkg::PH_WAIT;
            end
          end
        end
        jsu_pkg::PH_PAIR_BS: begin
          if (b == CH_BSLASH) begin
            phase_next = jsu_pkg::PH_PAIR_U;
          end else begin
            phase_next     = jsu_pkg::PH_WAIT;
            code_unit_next = '0;
            high_part_next = '0;
          end
        end
        jsu_pkg::PH_PAIR_U: begin
          if (b == CH_U) begin
            phase_next           = jsu_pkg::PH_HEX_LO;
            code_unit_next       = '0;
            hex_digits_seen_next = '0;
          end else begin
            phase_next     = jsu_pkg::PH_WAIT;
            code_unit_next = '0;
            high_part_next = '0;
          end
        end
        default: begin
          phase_next           = (b == CH_QUOTE) ? jsu_pkg::PH_STR : jsu_pkg::PH_WAIT;
          code_unit_next       = '0;
          high_part_next       = '0;
          hex_digits_seen_next = '0;
        end
      endcase
    end
  end

  // request to the back end
  always_comb begin
    cmd_valid       = 1'b0;
    push_cmd.kind   = jsu_pkg::KIND_BYTE;
    push_cmd.err    = jsu_pkg::ERR_NONE;
    push_cmd.cp     = '0;
    push_cmd.len_m1 = 2'd0;
    if (in_ch.input_ends) begin
      cmd_valid     = 1'b1;
      push_cmd.kind = jsu_pkg::KIND_ERR;
      push_cmd.err  = (phase == jsu_pkg::PH_WAIT) ? jsu_pkg::ERR_NO_OPEN
                                                  : jsu_pkg::ERR_EARLY_END;
    end else begin
      case (phase)
        jsu_pkg::PH_STR: begin
          if (b == CH_QUOTE) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_CLOSE;
          end else if (b <= 8'h1F) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_ERR;
            push_cmd.err  = jsu_pkg::ERR_CTRL_CHAR;
          end else if (b != CH_BSLASH) begin
            // raw bytes, including 0x80 and above, pass through as one byte
            cmd_valid   = 1'b1;
            push_cmd.cp = {13'd0, b};
          end
        end
        jsu_pkg::PH_ESC: begin
          cmd_valid = 1'b1;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_cmd.cp = {13'd0, b};
            CH_B: push_cmd.cp = 21'h08;
            CH_F: push_cmd.cp = 21'h0C;
            CH_N: push_cmd.cp = 21'h0A;
            CH_R: push_cmd.cp = 21'h0D;
            CH_T: push_cmd.cp = 21'h09;
            CH_U: cmd_valid = 1'b0;
            default: begin
              push_cmd.kind = jsu_pkg::KIND_ERR;
              push_cmd.err  = jsu_pkg::ERR_BAD_ESC;
            end
          endcase
        end
        jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
          if (!hex_ok) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_ERR;
            push_cmd.err  = (phase == jsu_pkg::PH_HEX_HI) ? jsu_pkg::ERR_BAD_HEX
                                                          : jsu_pkg::ERR_BAD_PAIR;
          end else if (hex_digits_seen == 2'd3) begin
            if (phase == jsu_pkg::PH_HEX_HI) begin
              if (is_lo) begin
                cmd_valid     = 1'b1;
                push_cmd.kind = jsu_pkg::KIND_ERR;
                push_cmd.err  = jsu_pkg::ERR_LONE_LOW;
              end else if (!is_hi) begin
                cmd_valid   = 1'b1;
                push_cmd.cp = {5'd0, cu_shift};
                if (cu_shift[15:11] != 5'd0) begin
                  push_cmd.len_m1 = 2'd2;
                end else if (cu_shift[10:7] != 4'd0) begin
                  push_cmd.len_m1 = 2'd1;
                end
              end
            end else begin
              cmd_valid = 1'b1;
              if (is_lo) begin
                push_cmd.cp     = pair_cp;
                push_cmd.len_m1 = 2'd3;
              end else begin
                push_cmd.kind = jsu_pkg::KIND_ERR;
                push_cmd.err  = jsu_pkg::ERR_BAD_PAIR;
              end
            end
          end
        end
        jsu_pkg::PH_PAIR_BS: begin
          if (b != CH_BSLASH) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_ERR;
            push_cmd.err  = jsu_pkg::ERR_BAD_PAIR;
          end
        end
        jsu_pkg::PH_PAIR_U: begin
          if (b != CH_U) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_ERR;
            push_cmd.err  = jsu_pkg::ERR_BAD_PAIR;
          end
        end
        default: begin
          if (b != CH_QUOTE) begin
            cmd_valid     = 1'b1;
            push_cmd.kind = jsu_pkg::KIND_ERR;
            push_cmd.err  = jsu_pkg::ERR_NO_OPEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= jsu_pkg::PH_WAIT;
      code_unit       <= '0;
      high_part       <= '0;
      hex_digits_seen <= '0;
    end else if (acc) begin
      phase           <= phase_next;
      code_unit       <= code_unit_next;
      high_part       <= high_part_next;
      hex_digits_seen <= hex_digits_seen_next;
    end
  end

endmodule : jsu_front
`default_nettype wire

### rtl/core/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// small request queue between front and back end
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  jsu_pkg::cmd_t      push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output jsu_pkg::cmd_t      pop_cmd,
  input  wire logic          pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : jsu_queue
`default_nettype wire

### rtl/core/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// expands requests into utf-8 bytes and status results, one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  input  jsu_pkg::cmd_t      pop_cmd,
  output logic               pop,
  jsu_out_if.source          out_ch
);

  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] enc;

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (len_m1)
      2'd0: r = cp[7:0];
      2'd1: r = (i == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (i)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (i)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

  assign load = pop_valid & (~out_ch.valid | out_ch.ready);
  assign last = (idx == pop_cmd.len_m1);
  assign pop  = load & last;
  assign enc  = (pop_cmd.kind == jsu_pkg::KIND_BYTE) ?
                utf8_byte(pop_cmd.cp, pop_cmd.len_m1, idx) : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        idx          <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.out_byte    <= enc;
      out_ch.out_kind    <= pop_cmd.kind;
      out_ch.error_code  <= pop_cmd.err;
      out_ch.last_of_run <= last;
    end
  end

endmodule : jsu_back
`default_nettype wire

### sim/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// self-checking bench for the json string unescaper: drives raw json bytes,
// predicts the utf-8 bytes, close marks and error codes per input byte, and
// checks every result in order under several idle, stall and hold-off mixes
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any handshake
  localparam int unsigned DRAIN_CYCLES = 8;     // settle time after the last result
  localparam int unsigned PHASE_ITEMS  = 65;    // random requests per idle mix
  localparam int unsigned PRINT_LIMIT  = 40;

  // characters with a meaning of their own in a json string
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] SLASH     = 8'h2F;
  localparam logic [7:0] LETTER_U  = 8'h75;

  // one expected result of the block
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic       last;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst;

  jsu_in_if  raw_ch ();
  jsu_out_if dec_ch ();

  json_string_unescape_utf8 uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (raw_ch),
    .out_ch (dec_ch)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: mirrors the parse state of the block
  // --------------------------------------------------------------------------
  phase_t      parse_phase;
  logic [15:0] unit_acc;     // hex digits of the current \u escape
  logic [9:0]  high_bits;    // high surrogate minus 0xd800
  logic [1:0]  digit_count;  // hex digits already taken

  dec_result_t byte_results[$];     // results of the byte being predicted
  dec_result_t awaited_results[$];  // decoded results not yet seen at the port

  // bench bookkeeping
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned kind_seen[3];
  int unsigned err_seen[8];
  int unsigned idle_cycles = 0;
  int unsigned holds_done = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void add_result(input logic [7:0] d, input kind_t k, input err_t e);
    dec_result_t r;
    r.data = d;
    r.kind = k;
    r.err  = e;
    r.last = 1'b0;
    byte_results = {byte_results, r};
  endfunction

  function automatic void go_idle();
    parse_phase = PH_WAIT;
    unit_acc    = '0;
    high_bits   = '0;
    digit_count = '0;
  endfunction

  // error result, the offending byte is swallowed and parsing starts over
  function automatic void reject(input err_t e);
    add_result(8'h00, KIND_ERR, e);
    go_idle();
  endfunction

  function automatic void put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_result(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      add_result(8'hC0 | cp[10:6], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[5:0], KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      add_result(8'hE0 | cp[15:12], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[11:6], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[5:0], KIND_BYTE, ERR_NONE);
    end else begin
      add_result(8'hF0 | cp[20:18], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[17:12], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[11:6], KIND_BYTE, ERR_NONE);
      add_result(8'h80 | cp[5:0], KIND_BYTE, ERR_NONE);
    end
  endfunction

  // 0..15 for a hex digit of either case, 16 for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return 5'(b - "0");
    if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
    if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
    return 5'd16;
  endfunction

  // works out every result one accepted byte causes and queues them in order
  function automatic void unescape_byte(input logic [7:0] b, input logic ends);
    logic [4:0]  h;
    dec_result_t r;
    if (ends) begin
      reject(parse_phase == PH_WAIT ? ERR_NO_OPEN : ERR_EARLY_END);
    end else begin
      case (parse_phase)
        PH_STR: begin
          if (b == QUOTE) begin
            add_result(8'h00, KIND_CLOSE, ERR_NONE);
            go_idle();
          end else if (b == BACKSLASH) begin
            parse_phase = PH_ESC;
          end else if (b <= 8'h1F) begin
            reject(ERR_CTRL_CHAR);
          end else begin
            add_result(b, KIND_BYTE, ERR_NONE);
          end
        end
        PH_ESC: begin
          parse_phase = PH_STR;
          case (b)
            QUOTE, BACKSLASH, SLASH: add_result(b, KIND_BYTE, ERR_NONE);
            "b": add_result(8'h08, KIND_BYTE, ERR_NONE);
            "f": add_result(8'h0C, KIND_BYTE, ERR_NONE);
            "n": add_result(8'h0A, KIND_BYTE, ERR_NONE);
            "r": add_result(8'h0D, KIND_BYTE, ERR_NONE);
            "t": add_result(8'h09, KIND_BYTE, ERR_NONE);
            LETTER_U: begin
              parse_phase = PH_HEX_HI;
              unit_acc    = '0;
              digit_count = '0;
            end
            default: reject(ERR_BAD_ESC);
          endcase
        end
        PH_HEX_HI, PH_HEX_LO: begin
          h = hex_value(b);
          if (h[4]) begin
            // a bad digit in the second escape of a pair breaks the pair
            reject(parse_phase == PH_HEX_HI ? ERR_BAD_HEX : ERR_BAD_PAIR);
          end else begin
            unit_acc = {unit_acc[11:0], h[3:0]};
            if (digit_count != 2'd3) begin
              digit_count = digit_count + 2'd1;
            end else begin
              digit_count = '0;
              if (parse_phase == PH_HEX_HI) begin
                if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                  high_bits   = unit_acc[9:0];  // 0xd800 has zero low bits
                  parse_phase = PH_PAIR_BS;
                end else if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                  reject(ERR_LONE_LOW);
                end else begin
                  put_utf8({5'd0, unit_acc});
                  parse_phase = PH_STR;
                end
              end else begin
                if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                  put_utf8(21'h10000 + {high_bits, 10'd0} + (unit_acc - 16'hDC00));
                  parse_phase = PH_STR;
                  high_bits   = '0;
                end else begin
                  reject(ERR_BAD_PAIR);
                end
              end
              if (parse_phase != PH_PAIR_BS) unit_acc = '0;
            end
          end
        end
        PH_PAIR_BS: begin
          if (b == BACKSLASH) parse_phase = PH_PAIR_U;
          else reject(ERR_BAD_PAIR);
        end
        PH_PAIR_U: begin
          if (b == LETTER_U) begin
            parse_phase = PH_HEX_LO;
            unit_acc    = '0;
            digit_count = '0;
          end else begin
            reject(ERR_BAD_PAIR);
          end
        end
        default: begin
          if (b == QUOTE) begin
            go_idle();
            parse_phase = PH_STR;
          end else begin
            reject(ERR_NO_OPEN);
          end
        end
      endcase
    end
    // the final result of this byte carries the run mark
    foreach (byte_results[i]) begin
      r = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      awaited_results = {awaited_results, r};
    end
    byte_results.delete();
  endfunction

  // every accepted request goes through the predictor
  always @(posedge clk) begin
    if (!rst && raw_ch.valid && raw_ch.ready) begin
      unescape_byte(raw_ch.in_byte, raw_ch.input_ends);
    end
  end

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // each accepted result is held against the oldest expectation
  always @(posedge clk) begin
    dec_result_t exp_r;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: byte %02h kind %0d err %0d",
                                  dec_ch.out_byte, dec_ch.out_kind, dec_ch.error_code));
      end else begin
        exp_r = awaited_results.pop_front();
        results_checked++;
        kind_seen[exp_r.kind]++;
        err_seen[exp_r.err]++;
        if (dec_ch.out_byte !== exp_r.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    dec_ch.out_byte, exp_r.data));
        if (dec_ch.out_kind !== exp_r.kind)
          report_mismatch($sformatf("out_kind %0d, expected %0d",
                                    dec_ch.out_kind, exp_r.kind));
        if (dec_ch.error_code !== exp_r.err)
          report_mismatch($sformatf("error_code %0d, expected %0d",
                                    dec_ch.error_code, exp_r.err));
        if (dec_ch.last_of_run !== exp_r.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                    dec_ch.last_of_run, exp_r.last));
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (raw_ch.valid && raw_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    dec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // offers one request, with random idle cycles first, and waits for the handshake
  task automatic send_item(input logic [7:0] b, input logic ends);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      raw_ch.valid <= 1'b0;
      @(posedge clk);
    end
    raw_ch.valid      <= 1'b1;
    raw_ch.in_byte    <= b;
    raw_ch.input_ends <= ends;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_end_of_input();
    send_item(8'($urandom_range(0, 255)), 1'b1);  // byte is don't-care here
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // lets every expected result come out before the next phase
  task automatic wait_drain();
    raw_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'h30 + d;
    if ($urandom_range(0, 1) == 0) return 8'h61 + d - 8'd10;
    return 8'h41 + d - 8'd10;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] b);
    case (b)
      QUOTE, BACKSLASH, SLASH, "b", "f", "n", "r", "t", LETTER_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 7))
      0: return QUOTE;
      1: return BACKSLASH;
      2: return SLASH;
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  task automatic send_hex_digits(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) send_item(hex_char(v[i*4 +: 4]), 1'b0);
  endtask

  task automatic send_unicode_escape(input logic [15:0] v);
    send_item(BACKSLASH, 1'b0);
    send_item(LETTER_U, 1'b0);
    send_hex_digits(v);
  endtask

  task automatic send_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == QUOTE || b == BACKSLASH);
    send_item(b, 1'b0);
  endtask

  // \u escape of a code point outside the surrogate range, 1 to 3 utf-8 bytes
  task automatic send_bmp_escape();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(16'h00, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hFFFF)); while (v >= 16'hD800 && v <= 16'hDFFF);
      end
    endcase
    send_unicode_escape(v);
  endtask

  task automatic send_surrogate_pair();
    send_unicode_escape(16'(16'hD800 + $urandom_range(0, 1023)));
    send_unicode_escape(16'(16'hDC00 + $urandom_range(0, 1023)));
  endtask

  // one well-formed piece of string content
  task automatic send_segment();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_plain_byte();
      4, 5: begin
        send_item(BACKSLASH, 1'b0);
        send_item(pick_escape_letter(), 1'b0);
      end
      6, 7: send_bmp_escape();
      default: send_surrogate_pair();
    endcase
  endtask

  // a fault inside the string; the block falls back to waiting for a quote
  task automatic send_fault();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: send_item(8'($urandom_range(8'h00, 8'h1F)), 1'b0);  // raw control byte
      1: begin  // unknown escape letter
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        send_item(BACKSLASH, 1'b0);
        send_item(b, 1'b0);
      end
      2: begin  // non-hex byte in a \u escape
        send_item(BACKSLASH, 1'b0);
        send_item(LETTER_U, 1'b0);
        repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (hex_value(b) != 5'd16);
        send_item(b, 1'b0);
      end
      3: send_unicode_escape(16'(16'hDC00 + $urandom_range(0, 1023)));  // low without high
      4: begin  // high surrogate with a broken follow-up
        send_unicode_escape(16'(16'hD800 + $urandom_range(0, 1023)));
        case ($urandom_range(0, 3))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == BACKSLASH);
            send_item(b, 1'b0);
          end
          1: begin
            do b = 8'($urandom_range(0, 255)); while (b == LETTER_U);
            send_item(BACKSLASH, 1'b0);
            send_item(b, 1'b0);
          end
          2: begin
            send_item(BACKSLASH, 1'b0);
            send_item(LETTER_U, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
            do b = 8'($urandom_range(0, 255)); while (hex_value(b) != 5'd16);
            send_item(b, 1'b0);
          end
          default: begin
            do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
            send_unicode_escape(v);
          end
        endcase
      end
      default: begin  // input ends somewhere inside the string
        case ($urandom_range(0, 4))
          0: ;
          1: send_item(BACKSLASH, 1'b0);
          2: begin
            send_item(BACKSLASH, 1'b0);
            send_item(LETTER_U, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
          end
          3: send_unicode_escape(16'(16'hD800 + $urandom_range(0, 1023)));
          default: begin
            send_unicode_escape(16'(16'hD800 + $urandom_range(0, 1023)));
            send_item(BACKSLASH, 1'b0);
            send_item(LETTER_U, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
          end
        endcase
        send_end_of_input();
      end
    endcase
  endtask

  // a string literal: mostly well formed, now and then cut short by a fault
  task automatic send_literal();
    int unsigned segs;
    bit          broken;
    broken = 1'b0;
    send_item(QUOTE, 1'b0);
    segs = $urandom_range(0, 7);
    for (int s = 0; s < segs && !broken; s++) begin
      if ($urandom_range(0, 99) < 7) begin
        send_fault();
        broken = 1'b1;
      end else begin
        send_segment();
      end
    end
    if (!broken) begin
      if ($urandom_range(0, 99) < 8) send_fault();
      else send_item(QUOTE, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // bytes and end of input while no string is open
  task automatic test_outside_string();
    send_text("x");
    send_item(8'h00, 1'b0);
    send_end_of_input();
    wait_drain();
  endtask

  // pass-through extremes, a simple escape, close, raw control byte
  task automatic test_plain_and_escape();
    send_text("\" ");
    send_item(8'hFF, 1'b0);
    send_text("\\n\"");
    send_text("\"");
    send_item(8'h1F, 1'b0);
    wait_drain();
  endtask

  // \u0000 as a zero byte, the highest pair, then the input ends mid-string
  task automatic test_unicode_escapes();
    send_text("\"\\u0000\\uDBFF\\udFfF");
    send_end_of_input();
    wait_drain();
  endtask

  // random literals and noise under one idle mix
  task automatic test_random_literals(input int unsigned idle_pct, input int unsigned hold_pct);
    int unsigned stop_at;
    logic [7:0]  noise;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    stop_at       = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0: begin
          noise = 8'($urandom_range(0, 255));
          send_item(noise == QUOTE ? 8'h00 : noise, 1'b0);
        end
        1: send_end_of_input();
        default: send_literal();
      endcase
    end
    wait_drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b1;
    send_item(QUOTE, 1'b0);
    repeat (2) send_surrogate_pair();
    repeat (5) send_plain_byte();
    send_item(QUOTE, 1'b0);
    wait_drain();
  endtask

  initial begin
    rst               <= 1'b1;
    raw_ch.valid      <= 1'b0;
    raw_ch.in_byte    <= 8'h00;
    raw_ch.input_ends <= 1'b0;
    go_idle();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_outside_string();
    test_plain_and_escape();
    test_unicode_escapes();

    test_random_literals(0, 0);
    test_random_literals(77, 0);
    test_random_literals(0, 77);
    test_random_literals(36, 36);

    test_output_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d requests, %0d results (%0d bytes, %0d closes, %0d errors), %0d hold-off",
             items_sent, results_checked, kind_seen[KIND_BYTE], kind_seen[KIND_CLOSE],
             kind_seen[KIND_ERR], holds_done);
    $display("errors by code 1..7: %0d %0d %0d %0d %0d %0d %0d", err_seen[1], err_seen[2],
             err_seen[3], err_seen[4], err_seen[5], err_seen[6], err_seen[7]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : json_string_unescape_utf8_test
